>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on a rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property held at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/v4ga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4ga_pkg
// types, codes and helper functions of the vector geometry alu
// ----------------------------------------------------------------------------
package v4ga_pkg;

  localparam int COMP_W      = 32;
  localparam int ACT_W       = 3;
  localparam int FAULT_W     = 2;
  localparam int SQRT_STAGES = 32;
  localparam int QUO_W       = 33;
  localparam int DEN_W       = 63;
  localparam int SAT_W       = 66;

  localparam logic [ACT_W-1:0] ACT_PDIV  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_NORM  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LEN   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QMUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DOT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CROSS = 3'd5;

  localparam logic [FAULT_W-1:0] FAULT_OK = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_DZ = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OV = 2'd2;

  localparam logic [COMP_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] MIN_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [COMP_W-1:0] val;
    logic              ov;
  } sat_t;

  // one digit of the integer square root
  function automatic sqrt_st_t sqrt_step(logic [63:0] rem, logic [31:0] root,
                                         int unsigned bitpos);
    logic [65:0] trial;
    sqrt_st_t    r;
    trial = ({34'd0, root} << (bitpos + 1)) + (66'd1 << (2 * bitpos));
    if ({2'b00, rem} >= trial) begin
      r.rem  = rem - trial[63:0];
      r.root = root | (32'd1 << bitpos);
    end else begin
      r.rem  = rem;
      r.root = root;
    end
    return r;
  endfunction

  // signed saturation of a magnitude to 32 bits
  function automatic sat_t sat_mag(logic neg, logic [SAT_W-1:0] mag);
    logic [SAT_W-1:0] lim;
    sat_t             r;
    lim = neg ? SAT_W'(MIN_NEG) : SAT_W'(MAX_POS);
    if (mag > lim) begin
      r.val = lim[COMP_W-1:0];
      r.ov  = 1'b1;
    end else begin
      r.val = mag[COMP_W-1:0];
      r.ov  = 1'b0;
    end
    if (neg) begin
      r.val = -r.val;
    end
    return r;
  endfunction

endpackage

>>> src/vec4_geometry_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_geometry_alu
// pipelined fixed-point vector and quaternion alu on two 4-component operands
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not held and returns one result
// item for each; the pipe holds the 32-stage square root (one root bit per stage)
// followed by the 33-stage restoring divider (one quotient bit per stage, three
// lanes for x, y and z). Every item, whatever its action, runs the full pipe, so
// results leave in input order. When the output is held the whole pipe stalls.
// Operands and results are signed fixed point with FRAC_BITS fraction bits.
// Rescales and divisions truncate toward zero, then saturate to 32 bits. fault
// reports a zero divisor (1) ahead of an overflow (2). Actions 6 and 7 return
// zeros with no fault.

`include "assert_macros.svh"

module vec4_geometry_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, 32 bits each
  input  logic [255:0] s_tdata,
  // action
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_x, r_y, r_z, r_w, 32 bits each
  output logic [127:0] m_tdata,
  // fault
  output logic [1:0]   m_tuser
);

  localparam int CW  = v4ga_pkg::COMP_W;
  localparam int NW  = 64 + FRAC_BITS;           // numerator magnitude width
  localparam int DW  = v4ga_pkg::DEN_W;
  localparam int QW  = v4ga_pkg::QUO_W;
  localparam int SW  = v4ga_pkg::SAT_W;
  localparam int SQN = v4ga_pkg::SQRT_STAGES;
  localparam int CMW = NW + DW;                  // divider compare width
  localparam logic [CW-1:0] ONE_Q = CW'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
  } div_ln_t;

  // item state through the square root stages
  typedef struct packed {
    logic [v4ga_pkg::ACT_W-1:0] action;
    logic [3:0][CW-1:0]         res;
    logic                       res_ov;
    logic [2:0]                 active;
    logic [2:0][NW-1:0]         num_mag;
    logic [2:0]                 num_neg;
    logic [DW-1:0]              den_mag;
    logic                       den_neg;
    logic [63:0]                rem;
    logic [31:0]                root;
  } sq_pay_t;

  // item state through the divider stages
  typedef struct packed {
    logic [v4ga_pkg::ACT_W-1:0] action;
    logic [3:0][CW-1:0]         res;
    logic                       res_ov;
    logic [2:0]                 active;
    logic [2:0]                 dz;
    logic [2:0]                 ovf;
    logic [2:0]                 neg;
    logic [2:0]                 nz;
    div_ln_t [2:0]              lane;
    logic [DW-1:0]              den;
  } dv_pay_t;

  function automatic logic [CW-1:0] abs32(logic signed [CW-1:0] x);
    return x[CW-1] ? CW'(-x) : CW'(x);
  endfunction

  // truncate a Q(2F) sum toward zero to Q(F) and saturate
  function automatic v4ga_pkg::sat_t rescale(logic signed [65:0] s);
    logic [65:0] mag;
    mag = s[65] ? 66'(-s) : 66'(s);
    return v4ga_pkg::sat_mag(s[65], SW'(mag >> FRAC_BITS));
  endfunction

  function automatic sq_pay_t sqrt_adv(sq_pay_t p, int unsigned bitpos);
    v4ga_pkg::sqrt_st_t st;
    sq_pay_t            r;
    st     = v4ga_pkg::sqrt_step(p.rem, p.root, bitpos);
    r      = p;
    r.rem  = st.rem;
    r.root = st.root;
    return r;
  endfunction

  function automatic div_ln_t div_step(div_ln_t l, logic [DW-1:0] d, int unsigned bitpos);
    logic [CMW-1:0] t;
    div_ln_t        r;
    t = {{(CMW - DW){1'b0}}, d} << bitpos;
    r = l;
    if ({{(CMW - NW){1'b0}}, l.rem} >= t) begin
      r.rem         = l.rem - t[NW-1:0];
      r.quo[bitpos] = 1'b1;
    end
    return r;
  endfunction

  function automatic dv_pay_t div_adv(dv_pay_t p, int unsigned bitpos);
    dv_pay_t r;
    r = p;
    for (int k = 0; k < 3; k++) begin
      r.lane[k] = div_step(p.lane[k], p.den, bitpos);
    end
    return r;
  endfunction

  // whole pipe advances unless the output item is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- stage 1: input register
  logic                       in_vld;
  logic [v4ga_pkg::ACT_W-1:0] in_act;
  logic signed [CW-1:0]       in_a [4];
  logic signed [CW-1:0]       in_b [4];

  // ---- stage 2: products
  logic                       mul_vld;
  logic [v4ga_pkg::ACT_W-1:0] mul_act;
  logic signed [CW-1:0]       mul_a [4];
  logic signed [63:0]         prod [4][4];   // prod[i][j] = a_i * b_j, x y z w
  logic signed [63:0]         sqr [3];

  // ---- stage 3: sums
  logic                       sum_vld;
  logic [v4ga_pkg::ACT_W-1:0] sum_act;
  logic signed [CW-1:0]       sum_a [4];
  logic signed [65:0]         qsum [4];
  logic signed [65:0]         csum [3];
  logic signed [65:0]         dsum;
  logic signed [63:0]         wprod;
  logic [63:0]                sqsum;

  // ---- root stages, divider stages
  logic [SQN:0]  sq_v;
  sq_pay_t       sq_p [SQN+1];
  logic [QW:0]   dv_v;
  dv_pay_t       dv_p [QW+1];

  sq_pay_t prep;
  dv_pay_t setup;

  always_comb begin
    v4ga_pkg::sat_t rq [4];
    v4ga_pkg::sat_t rc [3];
    v4ga_pkg::sat_t rw;
    logic [65:0]    dmag;
    logic [CW-1:0]  wa;
    for (int k = 0; k < 4; k++) rq[k] = rescale(qsum[k]);
    for (int k = 0; k < 3; k++) rc[k] = rescale(csum[k]);
    rw   = rescale(66'(wprod));
    dmag = dsum[65] ? 66'(-dsum) : 66'(dsum);
    wa   = abs32(sum_a[3]);
    prep = '0;
    prep.action = sum_act;
    prep.rem    = sqsum;
    for (int k = 0; k < 3; k++) begin
      prep.num_mag[k] = NW'(abs32(sum_a[k])) << FRAC_BITS;
      prep.num_neg[k] = sum_a[k][CW-1];
    end
    prep.den_mag = DW'(wa);
    prep.den_neg = sum_a[3][CW-1];
    case (sum_act)
      v4ga_pkg::ACT_PDIV, v4ga_pkg::ACT_NORM: begin
        prep.active = 3'b111;
      end
      v4ga_pkg::ACT_LEN: begin
        prep.active = 3'b001;
      end
      v4ga_pkg::ACT_DOT: begin
        prep.active     = 3'b001;
        prep.num_mag[0] = NW'(dmag[63:0]) << FRAC_BITS;
        prep.num_neg[0] = dsum[65];
        prep.den_mag    = wprod[63] ? DW'(-wprod) : DW'(wprod);
        prep.den_neg    = wprod[63];
      end
      v4ga_pkg::ACT_QMUL: begin
        for (int k = 0; k < 4; k++) prep.res[k] = rq[k].val;
        prep.res_ov = rq[0].ov | rq[1].ov | rq[2].ov | rq[3].ov;
      end
      v4ga_pkg::ACT_CROSS: begin
        for (int k = 0; k < 3; k++) prep.res[k] = rc[k].val;
        prep.res[3] = rw.val;
        prep.res_ov = rc[0].ov | rc[1].ov | rc[2].ov | rw.ov;
      end
      default: begin
        prep.active = 3'b000;
      end
    endcase
  end

  // length is known here: patch it in, then check the divisions
  always_comb begin
    sq_pay_t p;
    p = sq_p[SQN];
    if (p.action == v4ga_pkg::ACT_NORM) begin
      p.den_mag = DW'(p.root);
      p.den_neg = 1'b0;
    end
    if (p.action == v4ga_pkg::ACT_LEN) begin
      p.num_mag[0] = NW'(p.root) << FRAC_BITS;
      p.num_neg[0] = 1'b0;
    end
    setup        = '0;
    setup.action = p.action;
    setup.res    = p.res;
    setup.res_ov = p.res_ov;
    setup.active = p.active;
    setup.den    = p.den_mag;
    for (int k = 0; k < 3; k++) begin
      setup.dz[k]       = p.active[k] && (p.den_mag == '0);
      setup.ovf[k]      = {{(CMW - NW){1'b0}}, p.num_mag[k]} >=
                          ({{(CMW - DW){1'b0}}, p.den_mag} << QW);
      setup.neg[k]      = p.num_neg[k] ^ p.den_neg;
      setup.nz[k]       = p.num_mag[k] != '0;
      setup.lane[k].rem = p.num_mag[k];
      setup.lane[k].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      mul_vld <= 1'b0;
      sum_vld <= 1'b0;
      sq_v    <= '0;
      dv_v    <= '0;
    end else if (en) begin
      in_vld  <= s_tvalid;
      mul_vld <= in_vld;
      sum_vld <= mul_vld;
      sq_v    <= {sq_v[SQN-1:0], sum_vld};
      dv_v    <= {dv_v[QW-1:0], sq_v[SQN]};
    end
    if (en) begin
      in_act <= s_tuser;
      for (int k = 0; k < 4; k++) begin
        in_a[k] <= s_tdata[k*CW +: CW];
        in_b[k] <= s_tdata[(k+4)*CW +: CW];
      end
      mul_act <= in_act;
      for (int i = 0; i < 4; i++) begin
        mul_a[i] <= in_a[i];
        for (int j = 0; j < 4; j++) prod[i][j] <= in_a[i] * in_b[j];
      end
      for (int k = 0; k < 3; k++) sqr[k] <= in_a[k] * in_a[k];
      sum_act <= mul_act;
      for (int k = 0; k < 4; k++) sum_a[k] <= mul_a[k];
      // hamilton product, w real part
      qsum[0] <= 66'(prod[0][3]) + 66'(prod[1][2]) - 66'(prod[2][1]) + 66'(prod[3][0]);
      qsum[1] <= 66'(prod[1][3]) + 66'(prod[2][0]) - 66'(prod[0][2]) + 66'(prod[3][1]);
      qsum[2] <= 66'(prod[2][3]) + 66'(prod[0][1]) - 66'(prod[1][0]) + 66'(prod[3][2]);
      qsum[3] <= 66'(prod[3][3]) - 66'(prod[0][0]) - 66'(prod[1][1]) - 66'(prod[2][2]);
      csum[0] <= 66'(prod[1][2]) - 66'(prod[2][1]);
      csum[1] <= 66'(prod[2][0]) - 66'(prod[0][2]);
      csum[2] <= 66'(prod[0][1]) - 66'(prod[1][0]);
      dsum    <= 66'(prod[0][0]) + 66'(prod[1][1]) + 66'(prod[2][2]);
      wprod   <= prod[3][3];
      sqsum   <= 64'($unsigned(sqr[0])) + 64'($unsigned(sqr[1])) + 64'($unsigned(sqr[2]));
      sq_p[0] <= prep;
      for (int i = 0; i < SQN; i++) sq_p[i+1] <= sqrt_adv(sq_p[i], SQN - 1 - i);
      dv_p[0] <= setup;
      for (int i = 0; i < QW; i++) dv_p[i+1] <= div_adv(dv_p[i], QW - 1 - i);
    end
  end

  // ---- final saturation and output register
  logic [3:0][CW-1:0]           r_next;
  logic [v4ga_pkg::FAULT_W-1:0] fault_next;

  always_comb begin
    dv_pay_t        p;
    v4ga_pkg::sat_t s;
    logic [CW-1:0]  lv [3];
    logic [2:0]     lov;
    p = dv_p[QW];
    for (int k = 0; k < 3; k++) begin
      s      = v4ga_pkg::sat_mag(p.neg[k], p.ovf[k] ? {SW{1'b1}} : SW'(p.lane[k].quo));
      lv[k]  = '0;
      lov[k] = 1'b0;
      if (p.active[k] && p.dz[k]) begin
        if (p.nz[k]) lv[k] = p.neg[k] ? v4ga_pkg::MIN_NEG : v4ga_pkg::MAX_POS;
      end else if (p.active[k]) begin
        lv[k]  = s.val;
        lov[k] = s.ov;
      end
    end
    r_next = '0;
    case (p.action)
      v4ga_pkg::ACT_PDIV, v4ga_pkg::ACT_NORM: begin
        r_next = {ONE_Q, lv[2], lv[1], lv[0]};
      end
      v4ga_pkg::ACT_LEN, v4ga_pkg::ACT_DOT: begin
        r_next[0] = lv[0];
      end
      v4ga_pkg::ACT_QMUL, v4ga_pkg::ACT_CROSS: begin
        r_next = p.res;
      end
      default: begin
        r_next = '0;
      end
    endcase
    if (|p.dz) begin
      fault_next = v4ga_pkg::FAULT_DZ;
    end else if ((|lov) || p.res_ov) begin
      fault_next = v4ga_pkg::FAULT_OV;
    end else begin
      fault_next = v4ga_pkg::FAULT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[QW];
    end
    if (en) begin
      m_tdata <= r_next;
      m_tuser <= fault_next;
    end
  end

  // ---- checks
  `ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(sq_v) && $stable(dv_v) && $stable(in_vld), "pipe valid bits moved while stalled")
  `ASSERT_NEXT(a_scalar_zero, clk, rst, en && dv_v[QW] && (dv_p[QW].action == v4ga_pkg::ACT_LEN || dv_p[QW].action == v4ga_pkg::ACT_DOT), m_tdata[127:32] == '0, "scalar item has nonzero y z w")
  `ASSERT_NEXT(a_w_one, clk, rst, en && dv_v[QW] && (dv_p[QW].action == v4ga_pkg::ACT_PDIV || dv_p[QW].action == v4ga_pkg::ACT_NORM), m_tdata[127:96] == ONE_Q, "divide item w is not one")
  `ASSERT_CLK(a_dz_active, clk, rst, !sq_v[SQN] || ((setup.dz & ~setup.active) == 3'b000), "zero divisor flagged on idle lane")

endmodule
